FILE: rtl/rrpaw_pkg.sv
// rrpaw_pkg: shared types and constants of the round-robin ping/ack watchdog
// transfer payloads, config register map, phase encoding, command and fault codes
// no dependencies
package rrpaw_pkg;

  // config port
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_POLL_PERIOD   = 2'd2;

  // register reset values
  localparam logic [4:0] RST_CHANNEL_COUNT = 5'd0;
  localparam logic [7:0] RST_ACK_TIMEOUT   = 8'd20;
  localparam logic [7:0] RST_POLL_PERIOD   = 8'd30;

  // command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // fault causes
  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_DEAD    = 2'd1;
  localparam logic [1:0] FAULT_NO_PING = 2'd2;
  localparam logic [1:0] FAULT_TIMEOUT = 2'd3;

  typedef enum logic [1:0] {
    PH_PING,
    PH_WAIT,
    PH_POLL,
    PH_HALT
  } phase_e;

  typedef struct packed {
    logic [4:0] channel_count;
    logic [7:0] ack_timeout_ticks;
    logic [7:0] poll_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         ack_channel;
    logic signed [31:0] ack_value;
    logic               target_alive;
    logic               ping_accepted;
  } in_item_t;

  typedef struct packed {
    logic               ping;
    logic [3:0]         ping_channel;
    logic               ack_ok;
    logic signed [31:0] ack_code;
    logic               kill_all;
    logic [1:0]         fault_cause;
    logic               halted;
  } out_item_t;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] fault;
  } core_status_t;

endpackage

FILE: rtl/rrpaw_regs.sv
// rrpaw_regs: APB-style configuration registers of the watchdog
// depends on rrpaw_pkg for the register map and cfg_t
module rrpaw_regs import rrpaw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count     <= RST_CHANNEL_COUNT;
      cfg_q.ack_timeout_ticks <= RST_ACK_TIMEOUT;
      cfg_q.poll_period_ticks <= RST_POLL_PERIOD;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CHANNEL_COUNT: cfg_q.channel_count     <= pwdata[4:0];
        REG_ACK_TIMEOUT:   cfg_q.ack_timeout_ticks <= pwdata[7:0];
        REG_POLL_PERIOD:   cfg_q.poll_period_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHANNEL_COUNT: prdata = {27'd0, cfg_q.channel_count};
      REG_ACK_TIMEOUT:   prdata = {24'd0, cfg_q.ack_timeout_ticks};
      REG_POLL_PERIOD:   prdata = {24'd0, cfg_q.poll_period_ticks};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/rrpaw_core.sv
// rrpaw_core: watchdog state machine, ack flag/code store and result forming
// depends on rrpaw_pkg for phase_e, item types and codes
module rrpaw_core import rrpaw_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_fire_i,
  input  in_item_t     item_i,
  input  cfg_t         cfg_i,
  output out_item_t    res_o,
  output core_status_t status_o
);

  // channel indexes are 4 bits, so at most 16 slots are ever reachable
  localparam int unsigned SLOTS    = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
  localparam int unsigned SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LIVE_CAP = (MAX_CHANNELS < 31) ? MAX_CHANNELS : 31;
  localparam logic [4:0]  LIVE_CAP_V = 5'(LIVE_CAP);
  localparam logic [4:0]  SLOTS_V    = 5'(SLOTS);

  phase_e      phase_q, phase_d;
  logic [3:0]  cur_q, cur_d;
  logic [7:0]  tick_q, tick_d;
  logic [1:0]  fault_q, fault_d;
  logic [SLOTS-1:0] flags_q;
  logic [31:0] codes_q [SLOTS];

  logic [4:0]  live;
  logic [4:0]  next_ch;
  logic [7:0]  tick_inc;
  logic        cur_in_range;
  logic        flag_hit;
  logic        flag_set, flag_clr;
  logic [3:0]  clr_ch;
  logic        ping, ack_ok;
  logic [31:0] ack_code;

  assign live         = (cfg_i.channel_count > LIVE_CAP_V) ? LIVE_CAP_V : cfg_i.channel_count;
  assign next_ch      = {1'b0, cur_q} + 5'd1;
  assign tick_inc     = tick_q + 8'd1;
  assign cur_in_range = ({1'b0, cur_q} < SLOTS_V);
  assign flag_hit     = cur_in_range && flags_q[cur_q[SLOT_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PING;
      cur_q   <= '0;
      tick_q  <= '0;
      fault_q <= FAULT_NONE;
    end else if (in_fire_i) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      tick_q  <= tick_d;
      fault_q <= fault_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    cur_d    = cur_q;
    tick_d   = tick_q;
    fault_d  = fault_q;
    flag_set = 1'b0;
    flag_clr = 1'b0;
    clr_ch   = cur_q;
    ping     = 1'b0;
    ack_ok   = 1'b0;
    ack_code = '0;
    if (phase_q != PH_HALT) begin
      case (item_i.cmd)
        CMD_STOP: phase_d = PH_HALT;
        CMD_ACK: begin
          flag_set = ({1'b0, item_i.ack_channel} < live);
        end
        CMD_TICK: begin
          unique case (phase_q)
            PH_PING: begin
              if (live != 5'd0) begin
                // a channel left beyond the count wraps to the first one
                if ({1'b0, cur_q} >= live) begin
                  cur_d = '0;
                end
                if (!item_i.target_alive) begin
                  fault_d = FAULT_DEAD;
                  phase_d = PH_HALT;
                end else if (!item_i.ping_accepted) begin
                  fault_d = FAULT_NO_PING;
                  phase_d = PH_HALT;
                end else begin
                  flag_clr = 1'b1;
                  clr_ch   = cur_d;
                  ping     = 1'b1;
                  phase_d  = PH_WAIT;
                  tick_d   = '0;
                end
              end
            end
            PH_WAIT: begin
              if (flag_hit) begin
                ack_ok   = 1'b1;
                ack_code = codes_q[cur_q[SLOT_W-1:0]];
                phase_d  = PH_POLL;
                tick_d   = '0;
                if (cfg_i.poll_period_ticks == 8'd0) begin
                  cur_d   = (next_ch >= live) ? 4'd0 : next_ch[3:0];
                  phase_d = PH_PING;
                end
              end else begin
                tick_d = tick_inc;
                if (tick_inc == 8'd0 || tick_inc >= cfg_i.ack_timeout_ticks) begin
                  fault_d = FAULT_TIMEOUT;
                  phase_d = PH_HALT;
                end
              end
            end
            PH_POLL: begin
              tick_d = tick_inc;
              if (tick_inc == 8'd0 || tick_inc >= cfg_i.poll_period_ticks) begin
                cur_d   = (next_ch >= live) ? 4'd0 : next_ch[3:0];
                phase_d = PH_PING;
                tick_d  = '0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // ack flags reset to clear; codes are only read behind a set flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (in_fire_i) begin
      if (flag_set) begin
        flags_q[item_i.ack_channel[SLOT_W-1:0]] <= 1'b1;
      end else if (flag_clr) begin
        flags_q[clr_ch[SLOT_W-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i && flag_set) begin
      codes_q[item_i.ack_channel[SLOT_W-1:0]] <= item_i.ack_value;
    end
  end

  always_comb begin
    res_o.ping         = ping;
    res_o.ping_channel = cur_d;
    res_o.ack_ok       = ack_ok;
    res_o.ack_code     = ack_code;
    res_o.kill_all     = (fault_d != FAULT_NONE);
    res_o.fault_cause  = fault_d;
    res_o.halted       = (phase_d == PH_HALT);
  end

  assign status_o.phase = phase_q;
  assign status_o.fault = fault_q;

endmodule

FILE: rtl/rrpaw_out_buf.sv
// rrpaw_out_buf: two-entry result buffer (output register plus skid stage)
// depends on rrpaw_pkg for out_item_t
module rrpaw_out_buf import rrpaw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      main_v_q, skid_v_q;
  out_item_t main_q, skid_q;
  logic      pop;

  assign pop     = main_v_q & out_ready_i;
  assign space_o = ~skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= item_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_q <= item_i;
      end else begin
        main_q <= item_i;
      end
    end
  end

  assign out_valid_o = main_v_q;
  assign out_item_o  = main_q;

endmodule

FILE: rtl/round_robin_ping_ack_watchdog_core.sv
// round_robin_ping_ack_watchdog_core: top level of the heartbeat watchdog
// depends on rrpaw_pkg, rrpaw_regs, rrpaw_core and rrpaw_out_buf
//
// Fail-fast heartbeat watchdog that checks its channels in turn. Every input
// transfer is a tick, an ack from a channel, or a stop, and every input
// transfer gives exactly one result transfer. On a tick in the ping phase
// the current channel must be alive and take the ping, else a fault latches;
// otherwise ping is pulsed and wait ticks are counted until that channel's
// ack flag is seen (ack_ok with the stored code) or ack_timeout_ticks is
// reached (fault). After a success the block spaces by poll_period_ticks and
// moves on, wrapping after channel_count channels. A fault sets kill_all and
// halts; stop halts with no fault; once halted all transfers are answered
// with the frozen state until reset.
// Rate: one input transfer per clock while the skid stage is free; the state
// update is a single pass from the accepted transfer into the state and
// result registers, the result landing in the output register or skid stage.
// A two-entry result buffer keeps input open while one finished result waits
// on out_ready_i. Registers sit at byte addresses 0, 4 and 8 and must be
// written only while the block is idle; the block itself does not check it.
module round_robin_ping_ack_watchdog_core import rrpaw_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // input transfers
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  // result transfers
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  cfg_t         cfg;
  out_item_t    res;
  core_status_t status;
  logic         in_fire;
  logic         buf_space;

  // an input transfer completes whenever the skid stage is free
  assign in_ready_o = buf_space;
  assign in_fire    = in_valid_i & buf_space;

  // configuration registers
  rrpaw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // phase machine, ack store and result forming
  rrpaw_core #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .item_i    (in_item_i),
    .cfg_i     (cfg),
    .res_o     (res),
    .status_o  (status)
  );

  // result register plus skid stage
  rrpaw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .item_i      (res),
    .space_o     (buf_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.phase == PH_HALT |=> status.phase == PH_HALT)
    else $error("watchdog left the halted phase");

  // a latched fault always comes with halt
  a_fault_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fault != FAULT_NONE |-> status.phase == PH_HALT)
    else $error("fault latched without halting");

  // skid stage only fills behind a full output register
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("skid stage full while output register empty");

  // a ping result always reports the wait phase next
  a_ping_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res.ping |=> status.phase == PH_WAIT)
    else $error("ping issued without entering wait");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for round_robin_ping_ack_watchdog_core
// drives tick/ack/stop transfers, predicts every result transfer and checks it
// depends on rrpaw_pkg and the watchdog rtl only
module tb_top;
  import rrpaw_pkg::*;

  localparam int MAX_CH = 16;
  // the command encoding leaves one code unused, the block must ignore it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // watchdog state as the bench sees it, config copy included
  typedef struct packed {
    logic [4:0]        chan_count;
    logic [7:0]        timeout;
    logic [7:0]        poll;
    phase_e            phase;
    logic [3:0]        cur;
    logic [7:0]        ticks;
    logic [15:0]       flags;
    logic [15:0][31:0] codes;
    logic [1:0]        fault;
  } wd_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // config port
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // transfer channels
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // stimulus waiting for the driver, and reports the block still owes us
  in_item_t  events_q[$];
  out_item_t reports_due_q[$];

  // dut_view follows accepted transfers, plan_view runs ahead with the generator
  wd_state_t dut_view;
  wd_state_t plan_view;
  logic      patient = 1'b0;
  int        mismatch_cnt = 0;

  // sender burst/gap bookkeeping
  int burst_left = 0;
  int gap_left = 0;
  // receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;
  int sink_phase = 0;

  round_robin_ping_ack_watchdog_core #(
    .MAX_CHANNELS(MAX_CH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // watchdog prediction
  // ---------------------------------------------------------------------------

  function automatic wd_state_t reset_view();
    wd_state_t s;
    s            = '0;
    s.chan_count = RST_CHANNEL_COUNT;
    s.timeout    = RST_ACK_TIMEOUT;
    s.poll       = RST_POLL_PERIOD;
    s.phase      = PH_PING;
    s.fault      = FAULT_NONE;
    return s;
  endfunction

  // counts above the channel limit saturate
  function automatic logic [4:0] live_of(input wd_state_t s);
    return (s.chan_count > 5'(MAX_CH)) ? 5'(MAX_CH) : s.chan_count;
  endfunction

  // move on to the next channel, wrapping past the live count
  function automatic void wd_advance(inout wd_state_t s);
    logic [4:0] nxt;
    nxt = {1'b0, s.cur} + 5'd1;
    if (nxt >= live_of(s)) nxt = '0;
    s.cur   = nxt[3:0];
    s.phase = PH_PING;
    s.ticks = '0;
  endfunction

  // one accepted transfer in, the report it must produce out
  function automatic out_item_t watchdog_step(inout wd_state_t s, input in_item_t it);
    out_item_t  r;
    logic [4:0] live;
    logic [3:0] ch;
    r    = '0;
    live = live_of(s);
    ch   = s.cur;
    if (s.phase != PH_HALT) begin
      case (it.cmd)
        CMD_STOP: s.phase = PH_HALT;
        CMD_ACK: begin
          // acks for unmonitored channels fall on the floor
          if (it.ack_channel < live) begin
            s.flags[it.ack_channel] = 1'b1;
            s.codes[it.ack_channel] = it.ack_value;
          end
        end
        CMD_TICK: begin
          case (s.phase)
            PH_PING: begin
              if (live != 0) begin
                // channel left over from a larger count wraps to zero
                if (ch >= live) begin
                  ch    = '0;
                  s.cur = '0;
                end
                if (!it.target_alive) begin
                  s.fault = FAULT_DEAD;
                  s.phase = PH_HALT;
                end else if (!it.ping_accepted) begin
                  s.fault = FAULT_NO_PING;
                  s.phase = PH_HALT;
                end else begin
                  s.flags[ch] = 1'b0;
                  r.ping      = 1'b1;
                  s.phase     = PH_WAIT;
                  s.ticks     = '0;
                end
              end
            end
            PH_WAIT: begin
              if (s.flags[ch]) begin
                r.ack_ok   = 1'b1;
                r.ack_code = s.codes[ch];
                s.phase    = PH_POLL;
                s.ticks    = '0;
                if (s.poll == 8'd0) wd_advance(s);
              end else begin
                s.ticks = s.ticks + 8'd1;
                if (s.ticks == 8'd0 || s.ticks >= s.timeout) begin
                  s.fault = FAULT_TIMEOUT;
                  s.phase = PH_HALT;
                end
              end
            end
            PH_POLL: begin
              s.ticks = s.ticks + 8'd1;
              if (s.ticks == 8'd0 || s.ticks >= s.poll) wd_advance(s);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    r.ping_channel = s.cur;
    r.kill_all     = (s.fault != FAULT_NONE);
    r.fault_cause  = s.fault;
    r.halted       = (s.phase == PH_HALT);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_item(input logic [1:0] cmd, input logic [3:0] ch,
                                         input logic [31:0] val, input logic alive,
                                         input logic acc);
    in_item_t it;
    it.cmd           = cmd;
    it.ack_channel   = ch;
    it.ack_value     = val;
    it.target_alive  = alive;
    it.ping_accepted = acc;
    return it;
  endfunction

  // well-formed traffic with random content, plus stray acks and unused codes
  function automatic in_item_t random_item();
    in_item_t it;
    logic     forced;
    it = make_item(CMD_TICK, 4'($urandom), $urandom, 1'($urandom), 1'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      it.cmd = ($urandom_range(0, 3) == 0) ? CMD_UNUSED : CMD_ACK;
      return it;
    end
    case (plan_view.phase)
      PH_PING: begin
        // a live channel must pass the ping check or the block halts for good
        if (live_of(plan_view) != 0) begin
          it.target_alive  = 1'b1;
          it.ping_accepted = 1'b1;
        end
      end
      PH_WAIT: begin
        // ack before the tick that would otherwise time out
        forced = !plan_view.flags[plan_view.cur] &&
                 (plan_view.ticks == 8'hff ||
                  ({1'b0, plan_view.ticks} + 9'd1 >= {1'b0, plan_view.timeout}));
        if (forced || (!patient && $urandom_range(0, 5) == 0)) begin
          it.cmd         = CMD_ACK;
          it.ack_channel = plan_view.cur;
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    out_item_t r;
    r = watchdog_step(plan_view, it);
    // some pings wait out nearly the whole timeout
    if (r.ping) patient = ($urandom_range(0, 3) == 0);
    events_q.push_back(it);
  endtask

  // block is idle once nothing is queued, offered or owed
  task automatic wait_idle();
    @(negedge clk_i);
    while (events_q.size() != 0 || in_valid || reports_due_q.size() != 0)
      @(negedge clk_i);
  endtask

  // setup cycle, then access cycle; the write lands on the access edge
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT: begin
        dut_view.chan_count  = val[4:0];
        plan_view.chan_count = val[4:0];
      end
      REG_ACK_TIMEOUT: begin
        dut_view.timeout  = val[7:0];
        plan_view.timeout = val[7:0];
      end
      REG_POLL_PERIOD: begin
        dut_view.poll  = val[7:0];
        plan_view.poll = val[7:0];
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_all(input logic [4:0] cnt, input logic [7:0] tmo, input logic [7:0] poll);
    cfg_write(REG_CHANNEL_COUNT, 32'(cnt));
    cfg_write(REG_ACK_TIMEOUT, 32'(tmo));
    cfg_write(REG_POLL_PERIOD, 32'(poll));
  endtask

  // random phase; never leave it mid-wait so a config change cannot strand an ack
  task automatic run_phase(input int n);
    repeat (n) send_item(random_item());
    while (plan_view.phase == PH_WAIT) send_item(random_item());
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // driver: input transfers in bursts with random gaps
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : drive_p
    in_item_t  nxt_item;
    logic      nxt_valid;
    out_item_t r;
    if (rst_ni) begin
      nxt_valid = in_valid;
      nxt_item  = in_item;
      if (in_valid && in_ready) begin
        r = watchdog_step(dut_view, in_item);
        reports_due_q.push_back(r);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (events_q.size() != 0) begin
          nxt_item  = events_q.pop_front();
          nxt_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= nxt_valid;
      in_item  <= nxt_item;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: result transfers against the oldest owed report
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : check_p
    out_item_t want;
    logic      nxt_ready;
    if (rst_ni && out_valid && out_ready) begin
      if (reports_due_q.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatch_cnt++;
      end else begin
        want = reports_due_q.pop_front();
        check_field("ping", 32'(want.ping), 32'(out_item.ping));
        check_field("ping_channel", 32'(want.ping_channel), 32'(out_item.ping_channel));
        check_field("ack_ok", 32'(want.ack_ok), 32'(out_item.ack_ok));
        check_field("ack_code", want.ack_code, out_item.ack_code);
        check_field("kill_all", 32'(want.kill_all), 32'(out_item.kill_all));
        check_field("fault_cause", 32'(want.fault_cause), 32'(out_item.fault_cause));
        check_field("halted", 32'(want.halted), 32'(out_item.halted));
      end
    end
    // stall pattern: free flow, coin flips, one in six, mostly ready
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 200);
    end else begin
      stall_left--;
    end
    sink_phase = (sink_phase == 5) ? 0 : sink_phase + 1;
    case (stall_mode)
      0:       nxt_ready = 1'b1;
      1:       nxt_ready = 1'($urandom_range(0, 1));
      2:       nxt_ready = (sink_phase == 0);
      default: nxt_ready = ($urandom_range(0, 3) != 0);
    endcase
    out_ready <= nxt_ready;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : seq_p
    int         halt_kind;
    logic [4:0] cnt;
    logic [7:0] tmo;
    logic [7:0] poll;
    dut_view  = reset_view();
    plan_view = reset_view();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config has no channels: ticks do nothing, acks are unmonitored
    send_item(make_item(CMD_TICK, 4'd0, 32'd0, 1'b0, 1'b0));
    send_item(make_item(CMD_ACK, 4'd0, 32'h5a5a5a5a, 1'b1, 1'b1));
    send_item(make_item(CMD_UNUSED, 4'($urandom), $urandom, 1'b1, 1'b0));
    wait_idle();

    // oversized count saturates, zero timeout, zero poll period
    write_all(5'd31, 8'd0, 8'd0);
    send_item(make_item(CMD_ACK, 4'd15, 32'h7fffffff, 1'b0, 1'b0));
    send_item(make_item(CMD_TICK, 4'd0, 32'd0, 1'b1, 1'b1));
    send_item(make_item(CMD_ACK, 4'd0, 32'h80000000, 1'b0, 1'b1));
    // ack already in, so the zero timeout does not bite; moves on at once
    send_item(make_item(CMD_TICK, 4'd0, 32'd0, 1'b0, 1'b0));
    // an ack that arrives before the ping gets wiped by it
    send_item(make_item(CMD_ACK, 4'd1, 32'hffffffff, 1'b0, 1'b0));
    send_item(make_item(CMD_TICK, 4'd0, 32'd0, 1'b1, 1'b1));
    send_item(make_item(CMD_ACK, 4'd1, 32'd0, 1'b1, 1'b0));
    send_item(make_item(CMD_TICK, 4'd0, 32'd0, 1'b0, 1'b1));
    wait_idle();

    // shrink the count under the current channel, widest timeout and poll
    write_all(5'd2, 8'd255, 8'd255);
    send_item(make_item(CMD_TICK, 4'd0, 32'd0, 1'b1, 1'b1));
    send_item(make_item(CMD_TICK, 4'd0, 32'd0, 1'b1, 1'b0));
    send_item(make_item(CMD_ACK, 4'd15, 32'h12345678, 1'b0, 1'b0));
    send_item(make_item(CMD_ACK, 4'd0, 32'd1, 1'b0, 1'b0));
    send_item(make_item(CMD_TICK, 4'd0, 32'd0, 1'b0, 1'b0));
    send_item(make_item(CMD_TICK, 4'd0, 32'd0, 1'b1, 1'b1));
    wait_idle();

    // random phases across the register ranges
    repeat (12) begin
      case ($urandom_range(0, 7))
        0:       cnt = 5'd0;
        1:       cnt = 5'd1;
        2:       cnt = 5'd16;
        3:       cnt = 5'd31;
        4:       cnt = 5'($urandom_range(17, 30));
        default: cnt = 5'($urandom_range(2, 15));
      endcase
      case ($urandom_range(0, 5))
        0:       tmo = 8'd1;
        1:       tmo = 8'd255;
        2:       tmo = 8'd0;
        3:       tmo = 8'($urandom_range(2, 6));
        default: tmo = 8'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       poll = 8'd0;
        1:       poll = 8'd255;
        2:       poll = 8'd1;
        default: poll = 8'($urandom_range(0, 12));
      endcase
      write_all(cnt, tmo, poll);
      run_phase(115);
    end

    // last phase ends in a halt: one of the three faults or a quiet stop
    write_all(5'($urandom_range(1, 16)), 8'($urandom_range(1, 6)), 8'($urandom_range(0, 4)));
    repeat (30) send_item(random_item());
    halt_kind = $urandom_range(0, 3);
    case (halt_kind)
      0, 1: begin
        while (plan_view.phase != PH_PING) send_item(random_item());
        send_item(make_item(CMD_TICK, 4'($urandom), $urandom, 1'(halt_kind), 1'b0));
      end
      2: begin
        // only ticks from here, so the next ping cannot be answered
        while (plan_view.phase != PH_HALT) begin
          if (plan_view.phase == PH_PING)
            send_item(make_item(CMD_TICK, 4'($urandom), $urandom, 1'b1, 1'b1));
          else
            send_item(make_item(CMD_TICK, 4'($urandom), $urandom, 1'($urandom), 1'($urandom)));
        end
      end
      default: send_item(make_item(CMD_STOP, 4'($urandom), $urandom, 1'($urandom), 1'($urandom)));
    endcase
    // everything after the halt is answered with the frozen state
    send_item(make_item(CMD_STOP, 4'($urandom), $urandom, 1'($urandom), 1'($urandom)));
    send_item(make_item(CMD_UNUSED, 4'($urandom), $urandom, 1'($urandom), 1'($urandom)));
    repeat (8) send_item(random_item());
    wait_idle();
    // registers stay writable while halted
    cfg_write(REG_CHANNEL_COUNT, 32'd3);
    repeat (4) send_item(random_item());
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && reports_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/rrpaw_pkg.sv
rtl/rrpaw_regs.sv
rtl/rrpaw_core.sv
rtl/rrpaw_out_buf.sv
rtl/round_robin_ping_ack_watchdog_core.sv
tb/tb_top.sv
